@@ rtl/spiral_route_transposition_top_assert.svh @@
// ----------------------------------------------------------------------------
// spiral_route_transposition_top_assert.svh
// Assertion macros for the spiral route transposition block.
// ----------------------------------------------------------------------------
`ifndef SPIRAL_ROUTE_TRANSPOSITION_TOP_ASSERT_SVH
`define SPIRAL_ROUTE_TRANSPOSITION_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SRT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srt assertion failed");
// next-cycle implication
`define SRT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srt assertion failed");
`else
`define SRT_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SRT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/srt_pkg.sv @@
// ----------------------------------------------------------------------------
// srt_pkg
// Shared types, constants and the letter decoder of the spiral route
// transposition block.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

   // letter code width (0..25)
   localparam int LETTER_W = 5;

   localparam logic [LETTER_W-1:0] PAD_CODE = 5'd23;   // 'X'
   localparam logic [6:0] CHAR_A = 7'd65;
   localparam logic [6:0] CHAR_X = 7'd88;
   localparam logic [6:0] CHAR_Z = 7'd90;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT_MODE = 2'd1;
   localparam int CSR_DATA_W = 6;

   typedef struct packed {
      logic                hit;
      logic [LETTER_W-1:0] code;
   } letter_type;

   // spiral walker control
   typedef struct packed {
      logic load;
      logic step;
   } spiral_ctrl_type;

   // fold case and map a letter to 0..25; other bytes give no hit
   function automatic letter_type decode_letter(input logic [7:0] ch);
      letter_type res;
      logic [7:0] diff;
      res  = '0;
      diff = '0;
      if (ch >= 8'd97 && ch <= 8'd122) begin
         diff     = ch - 8'd97;
         res.hit  = 1'b1;
         res.code = diff[LETTER_W-1:0];
      end else if (ch >= 8'd65 && ch <= 8'd90) begin
         diff     = ch - 8'd65;
         res.hit  = 1'b1;
         res.code = diff[LETTER_W-1:0];
      end
      return res;
   endfunction

endpackage

`default_nettype wire

@@ rtl/srt_ram.sv @@
// ----------------------------------------------------------------------------
// srt_ram
// Single-write, single-read synchronous letter memory, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_ram import srt_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                clock,
   input  wire logic                wr_en,
   input  wire logic [AW-1:0]       wr_addr,
   input  wire logic [LETTER_W-1:0] wr_data,
   input  wire logic [AW-1:0]       rd_addr,
   output logic      [LETTER_W-1:0] rd_data
);

   logic [LETTER_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ rtl/srt_spiral.sv @@
// ----------------------------------------------------------------------------
// srt_spiral
// Spiral address walker: down the right column, left along the bottom,
// up the left column, right along the top, then inward. Gives one
// row-major cell index per step.
// ----------------------------------------------------------------------------
`default_nettype none

module srt_spiral import srt_pkg::*; #(
   parameter int AW = 6,
   parameter int CW = 7
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire spiral_ctrl_type ctrl,
   input  wire logic [AW-1:0]   rows_m1,
   input  wire logic [AW-1:0]   cols_m1,
   input  wire logic [CW-1:0]   cols,
   output logic      [AW-1:0]   idx,
   output logic                 last
);

   typedef enum logic [1:0] {
      D_DOWN,
      D_LEFT,
      D_UP,
      D_RIGHT
   } dir_type;

   dir_type       dir_ff, dir_in;
   logic [AW-1:0] r_ff, r_in, c_ff, c_in;
   logic [AW-1:0] top_ff, top_in, bot_ff, bot_in;
   logic [AW-1:0] lft_ff, lft_in, rgt_ff, rgt_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] stride;
   logic          at_end, fin;

   assign stride = AW'(cols);
   assign idx    = idx_ff;
   assign last   = at_end && fin;

   // end of the current leg, and whether turning would leave no cells
   always_comb begin
      case (dir_ff)
         D_DOWN: begin
            at_end = (r_ff == bot_ff);
            fin    = (rgt_ff == lft_ff);
         end
         D_LEFT: begin
            at_end = (c_ff == lft_ff);
            fin    = (bot_ff == top_ff);
         end
         D_UP: begin
            at_end = (r_ff == top_ff);
            fin    = (lft_ff == rgt_ff);
         end
         D_RIGHT: begin
            at_end = (c_ff == rgt_ff);
            fin    = (top_ff == bot_ff);
         end
         default: begin
            at_end = 1'b1;
            fin    = 1'b1;
         end
      endcase
   end

   // next position; each turn moves to a neighbor cell
   always_comb begin
      dir_in = dir_ff;
      r_in   = r_ff;
      c_in   = c_ff;
      top_in = top_ff;
      bot_in = bot_ff;
      lft_in = lft_ff;
      rgt_in = rgt_ff;
      case (dir_ff)
         D_DOWN: begin
            if (!at_end) begin
               r_in = r_ff + 1'b1;
            end else begin
               rgt_in = rgt_ff - 1'b1;
               c_in   = c_ff - 1'b1;
               dir_in = D_LEFT;
            end
         end
         D_LEFT: begin
            if (!at_end) begin
               c_in = c_ff - 1'b1;
            end else begin
               bot_in = bot_ff - 1'b1;
               r_in   = r_ff - 1'b1;
               dir_in = D_UP;
            end
         end
         D_UP: begin
            if (!at_end) begin
               r_in = r_ff - 1'b1;
            end else begin
               lft_in = lft_ff + 1'b1;
               c_in   = c_ff + 1'b1;
               dir_in = D_RIGHT;
            end
         end
         D_RIGHT: begin
            if (!at_end) begin
               c_in = c_ff + 1'b1;
            end else begin
               top_in = top_ff + 1'b1;
               r_in   = r_ff + 1'b1;
               dir_in = D_DOWN;
            end
         end
         default: begin
            dir_in = D_DOWN;
         end
      endcase
   end

   // row-major index follows the direction taken
   always_comb begin
      case (dir_in)
         D_DOWN:  idx_in = idx_ff + stride;
         D_LEFT:  idx_in = idx_ff - 1'b1;
         D_UP:    idx_in = idx_ff - stride;
         D_RIGHT: idx_in = idx_ff + 1'b1;
         default: idx_in = idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= D_DOWN;
      end else if (ctrl.load) begin
         dir_ff <= D_DOWN;
      end else if (ctrl.step) begin
         dir_ff <= dir_in;
      end
      if (ctrl.load) begin
         r_ff   <= '0;
         c_ff   <= cols_m1;
         top_ff <= '0;
         bot_ff <= rows_m1;
         lft_ff <= '0;
         rgt_ff <= cols_m1;
         idx_ff <= cols_m1;
      end else if (ctrl.step) begin
         r_ff   <= r_in;
         c_ff   <= c_in;
         top_ff <= top_in;
         bot_ff <= bot_in;
         lft_ff <= lft_in;
         rgt_ff <= rgt_in;
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/spiral_route_transposition_top.sv @@
// ----------------------------------------------------------------------------
// spiral_route_transposition_top
// Spiral route transposition: collects message letters, then emits the
// grid read along a spiral (encrypt) or filled along a spiral and read
// row by row (decrypt).
//
//   Channel  Ports                        Transfer
//   request  start/busy, req_*            start && !busy
//   result   rsp_valid, rsp_*             rsp_valid, no stall
//   config   csr_valid/csr_ready, csr_*   csr_valid && csr_ready
//
// Letters load at one byte per cycle while not busy, through the letter store
// write port. End of message: sizing adds one row per step (one add and
// compare per row, one more step when letters are cut), then encrypt emits one
// letter per cycle, rows*cols letters in all, from the letter store; decrypt
// first spirals the letters into the grid memory, passes a gap state, then
// emits rows*cols letters.
// busy is high from end of message until the cycle that shows the last letter.
// Synchronous reset clears the letter count and control; memories are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "spiral_route_transposition_top_assert.svh"

module spiral_route_transposition_top import srt_pkg::*; #(
   parameter int CAPACITY = 64
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [7:0]           req_in_char,
   input  wire logic                 req_end_of_message,
   output logic                      rsp_valid,
   output logic [6:0]                rsp_out_char,
   output logic                      rsp_last_of_run,
   output logic                      rsp_overflow,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW       = $clog2(CAPACITY);
   localparam int CW       = $clog2(CAPACITY + 1);
   localparam int MAX_COLS = (CAPACITY < 32) ? CAPACITY : 32;

   typedef enum logic [2:0] {
      S_LOAD,
      S_SIZE,
      S_WALK,
      S_GAP,
      S_ROWS
   } state_type;

   state_type           state_ff, state_in;
   logic [5:0]          column_count_ff;
   logic                decrypt_mode_ff;
   logic [CW-1:0]       count_ff, count_in;
   logic                seen_ff, seen_in;
   logic [CW-1:0]       n_ff, n_in;
   logic                ovf_ff, ovf_in;
   logic [CW-1:0]       cols_ff, cols_in;
   logic                mode_ff, mode_in;
   logic [CW-1:0]       acc_ff, acc_in;
   logic [AW-1:0]       rows_ff, rows_in;
   logic [CW-1:0]       k_ff, k_in;
   logic                e_valid_ff, e_valid_in;
   logic                e_pad_ff, e_pad_in;
   logic                e_last_ff, e_last_in;
   logic                e_grid_ff, e_grid_in;
   logic                w_valid_ff, w_valid_in;
   logic                w_pad_ff, w_pad_in;
   logic [AW-1:0]       w_idx_ff, w_idx_in;

   letter_type          letter;
   logic                accept;
   logic                room;
   logic [CW-1:0]       cols_sat;
   logic [CW:0]         acc_sum;
   spiral_ctrl_type     sp_ctrl;
   logic [AW-1:0]       sp_idx;
   logic                sp_last;
   logic                st_wr_en;
   logic [AW-1:0]       st_rd_addr;
   logic [LETTER_W-1:0] st_rd_data;
   logic [LETTER_W-1:0] gr_rd_data;
   logic [LETTER_W-1:0] gr_wr_data;
   logic [LETTER_W-1:0] e_code;

   assign busy      = (state_ff != S_LOAD);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign letter    = decode_letter(req_in_char);
   assign room      = (count_ff < CW'(CAPACITY));
   assign acc_sum   = {1'b0, acc_ff} + {1'b0, cols_ff};

   // column count held to 2..MAX_COLS
   always_comb begin
      if (column_count_ff < 6'd2) begin
         cols_sat = CW'(2);
      end else if (32'(column_count_ff) > MAX_COLS) begin
         cols_sat = CW'(MAX_COLS);
      end else begin
         cols_sat = CW'(column_count_ff);
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= 6'd2;
         decrypt_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_COLUMN_COUNT: column_count_ff <= csr_wdata;
            CSR_DECRYPT_MODE: decrypt_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      seen_in    = seen_ff;
      n_in       = n_ff;
      ovf_in     = ovf_ff;
      cols_in    = cols_ff;
      mode_in    = mode_ff;
      acc_in     = acc_ff;
      rows_in    = rows_ff;
      k_in       = k_ff;
      e_valid_in = 1'b0;
      e_pad_in   = e_pad_ff;
      e_last_in  = e_last_ff;
      e_grid_in  = e_grid_ff;
      w_valid_in = 1'b0;
      w_pad_in   = w_pad_ff;
      w_idx_in   = w_idx_ff;
      sp_ctrl    = '0;
      case (state_ff)
         S_LOAD: begin
            if (accept) begin
               if (letter.hit && room) begin
                  count_in = count_ff + 1'b1;
               end else if (letter.hit) begin
                  seen_in = 1'b1;
               end
               if (req_end_of_message) begin
                  n_in     = count_in;
                  ovf_in   = seen_in;
                  count_in = '0;
                  seen_in  = 1'b0;
                  cols_in  = cols_sat;
                  mode_in  = decrypt_mode_ff;
                  acc_in   = '0;
                  rows_in  = '0;
                  state_in = S_SIZE;
               end
            end
         end
         S_SIZE: begin
            // grow whole rows until the letters fit or the store runs out
            if (acc_ff >= n_ff) begin
               if (n_ff == '0) begin
                  state_in = S_LOAD;
               end else begin
                  sp_ctrl.load = 1'b1;
                  k_in         = '0;
                  state_in     = S_WALK;
               end
            end else if (acc_sum > (CW+1)'(CAPACITY)) begin
               n_in   = acc_ff;
               ovf_in = 1'b1;
            end else begin
               acc_in  = acc_sum[CW-1:0];
               rows_in = rows_ff + 1'b1;
            end
         end
         S_WALK: begin
            sp_ctrl.step = 1'b1;
            k_in         = k_ff + 1'b1;
            if (!mode_ff) begin
               e_valid_in = 1'b1;
               e_pad_in   = ({{(CW-AW){1'b0}}, sp_idx} >= n_ff);
               e_last_in  = sp_last;
               e_grid_in  = 1'b0;
            end else begin
               w_valid_in = 1'b1;
               w_idx_in   = sp_idx;
               w_pad_in   = (k_ff >= n_ff);
            end
            if (sp_last) begin
               state_in = mode_ff ? S_GAP : S_LOAD;
            end
         end
         S_GAP: begin
            // last grid write lands before the row readout starts
            k_in     = '0;
            state_in = S_ROWS;
         end
         S_ROWS: begin
            e_valid_in = 1'b1;
            e_pad_in   = 1'b0;
            e_grid_in  = 1'b1;
            e_last_in  = (k_ff == CW'(acc_ff - 1'b1));
            k_in       = k_ff + 1'b1;
            if (e_last_in) begin
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         seen_ff    <= 1'b0;
         e_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         seen_ff    <= seen_in;
         e_valid_ff <= e_valid_in;
         w_valid_ff <= w_valid_in;
      end
      n_ff      <= n_in;
      ovf_ff    <= ovf_in;
      cols_ff   <= cols_in;
      mode_ff   <= mode_in;
      acc_ff    <= acc_in;
      rows_ff   <= rows_in;
      k_ff      <= k_in;
      e_pad_ff  <= e_pad_in;
      e_last_ff <= e_last_in;
      e_grid_ff <= e_grid_in;
      w_pad_ff  <= w_pad_in;
      w_idx_ff  <= w_idx_in;
   end

   // letter store: written in arrival order
   assign st_wr_en   = accept && letter.hit && room;
   assign st_rd_addr = mode_ff ? k_ff[AW-1:0] : sp_idx;

   srt_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (letter.code),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // grid memory: spiral-filled in decrypt mode
   assign gr_wr_data = w_pad_ff ? PAD_CODE : st_rd_data;

   srt_ram #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_grid (
      .clock   (clock),
      .wr_en   (w_valid_ff),
      .wr_addr (w_idx_ff),
      .wr_data (gr_wr_data),
      .rd_addr (k_ff[AW-1:0]),
      .rd_data (gr_rd_data)
   );

   srt_spiral #(
      .AW (AW),
      .CW (CW)
   ) u_spiral (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (sp_ctrl),
      .rows_m1 (AW'(rows_ff - 1'b1)),
      .cols_m1 (AW'(cols_ff - 1'b1)),
      .cols    (cols_ff),
      .idx     (sp_idx),
      .last    (sp_last)
   );

   // result port
   assign e_code          = e_grid_ff ? gr_rd_data : st_rd_data;
   assign rsp_valid       = e_valid_ff;
   assign rsp_out_char    = e_pad_ff ? CHAR_X : (CHAR_A + {2'b00, e_code});
   assign rsp_last_of_run = e_last_ff;
   assign rsp_overflow    = ovf_ff;

   `SRT_ASSERT_NEXT(a_last_ends_run, clock, reset, rsp_valid && rsp_last_of_run, !rsp_valid)
   `SRT_ASSERT_NEXT(a_eom_no_result, clock, reset, accept && req_end_of_message, !rsp_valid)
   `SRT_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `SRT_ASSERT_NOW(a_letter_range, clock, reset, rsp_valid, rsp_out_char >= CHAR_A && rsp_out_char <= CHAR_Z)
   `SRT_ASSERT_NOW(a_no_write_idle, clock, reset, state_ff == S_LOAD, !w_valid_ff)

endmodule

`default_nettype wire
